FILE: hw/rtl/expiring_peer_negative_cache_macros.svh
// assertion macros shared by the checker of the expiring peer negative cache
// no dependencies; included by bare file name
`ifndef EXPIRING_PEER_NEGATIVE_CACHE_MACROS_SVH
`define EXPIRING_PEER_NEGATIVE_CACHE_MACROS_SVH

// same-cycle implication, disabled during reset
`define EPNC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("epnc: same-cycle check failed");

// next-cycle implication, disabled during reset
`define EPNC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("epnc: next-cycle check failed");

`endif

FILE: hw/rtl/epnc_pkg.sv
// package of the expiring peer negative cache: item kinds, fsm states,
// controller/datapath command and status structs, expiry helper; no dependencies
package epnc_pkg;

    localparam int TIME_W  = 32;
    localparam int CNT_W   = 4;
    localparam int CNT_SAT = 15;

    typedef enum logic [1:0] {
        K_LOOKUP = 2'd0,
        K_INSERT = 2'd1,
        K_ERASE  = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_WRITE,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic eval;
        logic wr_ins;
        logic clr;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic is_clear;
        logic is_insert;
    } t_dp_sts;

    // wrap-safe test: now at or after deadline
    function automatic logic time_reached(input logic [TIME_W-1:0] now,
                                          input logic [TIME_W-1:0] deadline);
        logic [TIME_W-1:0] diff;
        diff = now - deadline;
        return !diff[TIME_W-1];
    endfunction

endpackage

FILE: hw/rtl/epnc_if.sv
// channel interfaces of the expiring peer negative cache: request and result
// depends on epnc_pkg
interface epnc_in_if import epnc_pkg::*; #(parameter int KEY_W = 56);
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [KEY_W-1:0]  peer_key;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] cooldown_ms;

    modport source(output valid, kind, peer_key, now_ms, cooldown_ms, input ready);
    modport sink(input valid, kind, peer_key, now_ms, cooldown_ms, output ready);
endinterface

interface epnc_out_if import epnc_pkg::*;;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [CNT_W-1:0] active_count;

    modport source(output valid, hit, active_count, input ready);
    modport sink(input valid, hit, active_count, output ready);
endinterface

FILE: hw/rtl/epnc_ctrl.sv
// controller of the expiring peer negative cache: scan sequencer and result flag
// depends on epnc_pkg
module epnc_ctrl import epnc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_READ;
            end
            S_READ: begin
                n_state = i_sts.is_clear ? S_DONE : S_EVAL;
            end
            S_EVAL: begin
                if (!i_sts.last)          n_state = S_READ;
                else if (i_sts.is_insert) n_state = S_WRITE;
                else                      n_state = S_DONE;
            end
            S_WRITE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_READ: begin
                o_cmd.clr = i_sts.is_clear;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                o_cmd.step = !i_sts.last;
            end
            S_WRITE: begin
                o_cmd.wr_ins = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // state and result flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load)  r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/epnc_dp.sv
// datapath of the expiring peer negative cache: entry memories, valid bits,
// stamp counter, per-entry evaluation and result register; depends on epnc_pkg
module epnc_dp import epnc_pkg::*; #(
    parameter int ENTRIES = 8,
    parameter int KEY_W   = 56
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [1:0]        i_kind,
    input  logic [KEY_W-1:0]  i_peer_key,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic [TIME_W-1:0] i_cooldown_ms,
    output logic              o_hit,
    output logic [CNT_W-1:0]  o_active_count
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // entry memories, no reset: valid bits gate every use
    logic [KEY_W-1:0]  m_key   [ENTRIES];
    logic [TIME_W-1:0] m_exp   [ENTRIES];
    logic [TIME_W-1:0] m_stamp [ENTRIES];

    logic [KEY_W-1:0]  r_rd_key;
    logic [TIME_W-1:0] r_rd_exp;
    logic [TIME_W-1:0] r_rd_stamp;

    logic [ENTRIES-1:0] r_valid;
    logic [TIME_W-1:0]  r_ctr;

    t_kind             r_kind;
    logic [KEY_W-1:0]  r_key;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_cool;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_sel;
    logic [TIME_W-1:0] r_min;
    logic              r_hit;
    logic              r_found;
    logic              r_was;
    logic [CW-1:0]     r_cnt;
    logic              r_o_hit;
    logic [CNT_W-1:0]  r_o_cnt;

    logic              v_cur, v_drop, v_new, key_eq, reached, cnt_inc;
    logic              lk_take, ins_stop, ins_lru;
    logic              sel_was, new_act;
    logic [TIME_W-1:0] stamp_new, exp_new;
    logic [CW-1:0]     cnt_fin;
    logic [31:0]       cnt_ext;
    logic              st_we;
    logic [IW-1:0]     st_addr;

    // evaluation of the entry under the scan index
    always_comb begin
        v_cur   = r_valid[r_idx];
        key_eq  = (r_rd_key == r_key);
        reached = time_reached(r_now, r_rd_exp);
        v_drop  = v_cur && !reached;
        case (r_kind)
            K_LOOKUP: v_new = v_drop;
            K_INSERT: v_new = v_drop;
            K_ERASE:  v_new = v_cur && !key_eq;
            default:  v_new = v_cur;
        endcase
        cnt_inc  = (r_kind == K_ERASE) ? (v_new && !reached) : v_new;
        lk_take  = (r_kind == K_LOOKUP) && !r_hit && v_drop && key_eq;
        ins_stop = (r_kind == K_INSERT) && !r_found && (!v_drop || key_eq);
        ins_lru  = (r_kind == K_INSERT) && !r_found && !ins_stop &&
                   ((r_idx == '0) || (r_rd_stamp < r_min));
    end

    // insert write-back values and final count
    always_comb begin
        stamp_new = r_ctr + TIME_W'(1);
        exp_new   = r_now + r_cool;
        sel_was   = r_found ? r_was : 1'b1;
        new_act   = !time_reached(r_now, exp_new);
        cnt_fin   = r_cnt - CW'(sel_was) + CW'(new_act);
        cnt_ext   = 32'(r_cnt);
        st_we     = (i_cmd.eval && lk_take) || i_cmd.wr_ins;
        st_addr   = i_cmd.wr_ins ? r_sel : r_idx;
    end

    // memory read and write ports
    always_ff @(posedge i_clk) begin
        r_rd_key   <= m_key[r_idx];
        r_rd_exp   <= m_exp[r_idx];
        r_rd_stamp <= m_stamp[r_idx];
        if (st_we) m_stamp[st_addr] <= stamp_new;
        if (i_cmd.wr_ins) begin
            m_key[r_sel] <= r_key;
            m_exp[r_sel] <= exp_new;
        end
    end

    // valid bits and stamp counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ctr   <= '0;
        end else if (i_cmd.clr) begin
            r_valid <= '0;
            r_ctr   <= '0;
        end else begin
            if (i_cmd.eval)   r_valid[r_idx] <= v_new;
            if (i_cmd.wr_ins) r_valid[r_sel] <= 1'b1;
            if (st_we)        r_ctr <= stamp_new;
        end
    end

    // item capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= t_kind'(i_kind);
            r_key   <= i_peer_key;
            r_now   <= i_now_ms;
            r_cool  <= i_cooldown_ms;
            r_idx   <= '0;
            r_sel   <= '0;
            r_min   <= '0;
            r_hit   <= 1'b0;
            r_found <= 1'b0;
            r_was   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.step) r_idx <= r_idx + IW'(1);
            if (i_cmd.eval) begin
                r_cnt <= r_cnt + CW'(cnt_inc);
                if (lk_take) r_hit <= 1'b1;
                if (ins_stop) begin
                    r_found <= 1'b1;
                    r_sel   <= r_idx;
                    r_was   <= v_drop;
                end else if (ins_lru) begin
                    r_sel <= r_idx;
                    r_min <= r_rd_stamp;
                end
            end
            if (i_cmd.wr_ins) r_cnt <= cnt_fin;
            if (i_cmd.clr)    r_cnt <= '0;
        end
    end

    // result register, count saturates
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_hit <= r_hit;
            r_o_cnt <= (cnt_ext > 32'(CNT_SAT)) ? CNT_W'(CNT_SAT) : cnt_ext[CNT_W-1:0];
        end
    end

    assign o_sts.last      = (r_idx == IW'(ENTRIES - 1));
    assign o_sts.is_clear  = (r_kind == K_CLEAR);
    assign o_sts.is_insert = (r_kind == K_INSERT);
    assign o_hit           = r_o_hit;
    assign o_active_count  = r_o_cnt;

endmodule

FILE: hw/rtl/expiring_peer_negative_cache.sv
// top level of the expiring peer negative cache: controller plus datapath
// depends on epnc_pkg, epnc_if, epnc_ctrl, epnc_dp
//
//  channel  dir  payload                                   beat when
//  i_in     in   kind, peer_key, now_ms, cooldown_ms       valid && ready
//  o_out    out  hit, active_count                         valid && ready
//
// one item at a time: the scan visits the entries in turn, each in a read
// state and then an evaluation state, through the registered read of the entry
// memories; insert adds a write state at the end and clear skips the scan.
// the result waits in an output register; the next beat is taken meanwhile,
// but a finished item holds until that register is free.
// synchronous active-low reset empties the table and zeroes the stamp counter.
module expiring_peer_negative_cache import epnc_pkg::*; #(
    parameter int ENTRIES = 8,
    parameter int KEY_W   = 56
) (
    input  logic i_clk,
    input  logic i_rst_n,
    epnc_in_if.sink    i_in,
    epnc_out_if.source o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;
    logic    out_valid;

    // sequencer
    epnc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // table and evaluation
    epnc_dp #(
        .ENTRIES (ENTRIES),
        .KEY_W   (KEY_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_in.kind),
        .i_peer_key     (i_in.peer_key),
        .i_now_ms       (i_in.now_ms),
        .i_cooldown_ms  (i_in.cooldown_ms),
        .o_hit          (o_out.hit),
        .o_active_count (o_out.active_count)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

FILE: hw/rtl/epnc_checker.sv
// port-level checks of the expiring peer negative cache, bound to the top level
// depends on epnc_pkg and expiring_peer_negative_cache_macros.svh
`include "expiring_peer_negative_cache_macros.svh"

module epnc_checker import epnc_pkg::*; #(
    parameter int ENTRIES = 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_hit,
    input logic [CNT_W-1:0] i_active_count
);

    localparam int CAP = (ENTRIES > CNT_SAT) ? CNT_SAT : ENTRIES;

    // a stalled result beat holds
    `EPNC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_hit) && $stable(i_active_count))

    // count never above the table size
    `EPNC_ASSERT_IMP(a_cnt_cap, i_clk, i_rst_n, i_out_valid, i_active_count <= CNT_W'(CAP))

    // one item at a time: no beat straight after a beat
    `EPNC_ASSERT_NXT(a_one_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind expiring_peer_negative_cache epnc_checker #(
    .ENTRIES (ENTRIES)
) u_epnc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_hit          (o_out.hit),
    .i_active_count (o_out.active_count)
);
